/* hdl/longest_common_substring_length_macros.svh */
// Assertion macros used by the checker of the longest common substring block.
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_MACROS_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define LCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcs check failed (same cycle)");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define LCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcs check failed (next cycle)");

`endif

/* hdl/lcs_pkg.sv */
// Package with the shared types and codes of the longest common substring block.
`default_nettype none

package lcs_pkg;

    localparam int OP_W  = 2;
    localparam int CH_W  = 8;
    localparam int RUN_W = 7;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;

    // Run lengths and the best length saturate at the top of the result field.
    localparam logic [RUN_W-1:0] LEN_CAP = 7'd127;

    typedef struct packed {
        logic append;
        logic start;
        logic finish;
        logic load_out;
    } lcs_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic row_empty;
        logic out_free;
    } lcs_status_t;

endpackage

`default_nettype wire

/* hdl/lcs_ctrl.sv */
// Controller state machine that sequences appends, sweeps and result hand-off.
`default_nettype none

module lcs_ctrl
    import lcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [OP_W-1:0]   in_op,
    output logic                   ready,
    output lcs_cmd_t               cmd,
    input  wire lcs_status_t       status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign ready  = (state_reg == ST_IDLE);
    assign accept = in_valid && ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        OP_SECOND:
                        begin
                            // An empty first string leaves everything unchanged.
                            if (!status.row_empty)
                            begin
                                cmd.start  = 1'b1;
                                state_next = ST_SWEEP;
                            end
                        end
                        OP_END:
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/lcs_dp.sv */
// Datapath with the string and run memories, the sweep pipeline and the result register.
`default_nettype none

module lcs_dp
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcs_cmd_t          cmd,
    output lcs_status_t            status,
    input  wire logic [CH_W-1:0]   ch,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [RUN_W:0]         out_data
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [CH_W-1:0]  fs_mem [MAX_LEN];
    logic [RUN_W-1:0] rr_mem [MAX_LEN];

    logic [LW-1:0]    first_len_reg;
    logic [RUN_W-1:0] best_reg;
    logic             ovf_reg;
    logic             row_clean_reg;
    logic             issue_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             p_valid_reg;
    logic [IW-1:0]    p_idx_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [RUN_W-1:0] prev_old_reg;
    logic [CH_W-1:0]  fs_q_reg;
    logic [RUN_W-1:0] rr_q_reg;
    logic [RUN_W-1:0] res_len_reg;
    logic             res_ovf_reg;
    logic             out_valid_reg;
    logic [RUN_W:0]   out_data_reg;

    logic             full;
    logic [LW-1:0]    len_m1;
    logic [IW-1:0]    last_idx;
    logic [RUN_W-1:0] old_run;
    logic [RUN_W-1:0] run_inc;
    logic [RUN_W-1:0] run_next;

    assign full     = (first_len_reg == LW'(MAX_LEN));
    assign len_m1   = first_len_reg - LW'(1);
    assign last_idx = len_m1[IW-1:0];

    // Right after a clear the run row reads as zeros until one sweep rewrites it.
    assign old_run  = row_clean_reg ? '0 : rr_q_reg;
    assign run_inc  = (prev_old_reg == LEN_CAP) ? LEN_CAP : prev_old_reg + RUN_W'(1);
    assign run_next = (fs_q_reg == ch_reg) ? run_inc : '0;

    assign status.sweep_done = p_valid_reg && (p_idx_reg == last_idx);
    assign status.row_empty  = (first_len_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            fs_mem[first_len_reg[IW-1:0]] <= ch;
        end
        if (issue_reg)
        begin
            fs_q_reg <= fs_mem[rd_idx_reg];
            rr_q_reg <= rr_mem[rd_idx_reg];
        end
        if (p_valid_reg)
        begin
            rr_mem[p_idx_reg] <= run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            row_clean_reg <= 1'b1;
            issue_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            p_valid_reg   <= 1'b0;
            p_idx_reg     <= '0;
            ch_reg        <= '0;
            prev_old_reg  <= '0;
            res_len_reg   <= '0;
            res_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cmd.append)
            begin
                if (!full)
                begin
                    first_len_reg <= first_len_reg + LW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                best_reg      <= '0;
                row_clean_reg <= 1'b1;
            end

            if (cmd.start)
            begin
                ch_reg       <= ch;
                rd_idx_reg   <= '0;
                issue_reg    <= 1'b1;
                prev_old_reg <= '0;
            end
            else if (issue_reg)
            begin
                if (rd_idx_reg == last_idx)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + IW'(1);
                end
            end

            p_valid_reg <= issue_reg;
            p_idx_reg   <= rd_idx_reg;

            if (p_valid_reg)
            begin
                prev_old_reg <= old_run;
                if (run_next > best_reg)
                begin
                    best_reg <= run_next;
                end
                if (p_idx_reg == last_idx)
                begin
                    row_clean_reg <= 1'b0;
                end
            end

            if (cmd.finish)
            begin
                res_len_reg   <= best_reg;
                res_ovf_reg   <= ovf_reg;
                best_reg      <= '0;
                first_len_reg <= '0;
                ovf_reg       <= 1'b0;
                row_clean_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {res_ovf_reg, res_len_reg};
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/longest_common_substring_length.sv */
// Top level of the longest common substring length block.
//
// Input beats arrive on the s_axis channel: tuser carries the operation and tdata the byte.
// Operation append adds a byte to the first string and forgets any runs so far; a byte
// past MAX_LEN is dropped and raises the overflow flag. Operation second-string sweeps the
// stored first string once, one position per cycle, through a pipelined read of the string
// and run memories, and holds the input off until the sweep is done. Append, and a
// second-string byte against an empty first string, do not stall the input.
// Operation end-of-pair latches the best length and overflow, clears the pair, and then
// waits until the output register is free, loads the result into it and raises m_axis
// tvalid; the input stalls meanwhile. The unused operation code is taken and ignored.
// The result sits in an output register, so new input beats are taken while it waits; only
// after a second end-of-pair beat does the input stall until the earlier result is taken.
// Reset clears the lengths, the flags and the output; no memory clearing pass is needed.
`default_nettype none

module longest_common_substring_length
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] ch
    input  wire logic [1:0]        s_axis_tuser,   // [1:0] op
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata    // [6:0] length, [7] overflow
);

    lcs_cmd_t    cmd;
    lcs_status_t status;

    lcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .ready    (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lcs_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .ch        (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* hdl/lcs_checker.sv */
// Port-level checker for the longest common substring block and its bind.
`default_nettype none
`include "longest_common_substring_length_macros.svh"

module lcs_checker
    import lcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    input  wire logic       s_axis_tready,
    input  wire logic [1:0] s_axis_tuser,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata
);

    logic end_beat;
    logic append_beat;

    assign end_beat    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_END);
    assign append_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_APPEND);

    `LCS_ASSERT_NEXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `LCS_ASSERT_NEXT(a_out_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `LCS_ASSERT_NEXT(a_end_blocks_input, end_beat, !s_axis_tready)
    `LCS_ASSERT_NEXT(a_append_single_cycle, append_beat, s_axis_tready)

endmodule

bind longest_common_substring_length lcs_checker u_lcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
